FILE: sv/dwg_pkg.sv
// Shared types, constants and helpers for the damped wave grid block.
// Used by dwg_ctrl, dwg_dp and damped_wave_grid_step; no dependencies.
package dwg_pkg;

   // Grid geometry and cell format
   localparam int GRID_X      = 128;
   localparam int GRID_Y      = 128;
   localparam int HEIGHT_BITS = 24;
   localparam int CELLS       = GRID_X * GRID_Y;
   localparam int NUM_LAYERS  = 3;
   localparam int LAYER_W     = 2;
   localparam int ADDR_W      = $clog2(CELLS);
   // raster counter also runs one row of lookahead past the last cell
   localparam int CNT_W       = $clog2(CELLS + GRID_X + 1);

   // Port field widths
   localparam int FUNC_W    = 3;
   localparam int XY_IN_W   = 7;
   localparam int VAL_W     = 24;
   localparam int COEF_W    = 16;
   localparam int RAD_W     = 3;
   localparam int CSR_IDX_W = 3;

   // Coordinate width wide enough for grid index, input index and radius
   localparam int XW      = $clog2(GRID_X);
   localparam int YW      = $clog2(GRID_Y);
   localparam int MAX_XY  = (XW > YW) ? XW : YW;
   localparam int CRD_W   = ((MAX_XY > XY_IN_W) ? MAX_XY : XY_IN_W) + 2;

   // Stencil arithmetic widths
   localparam int LAP_W   = HEIGHT_BITS + 2;
   localparam int DIF_W   = HEIGHT_BITS + 1;
   localparam int PRD_W   = LAP_W + COEF_W + 1;
   localparam int ACC_W   = HEIGHT_BITS + COEF_W + 5;
   localparam int FRAC_SH = COEF_W;
   localparam int RND_W   = ACC_W - FRAC_SH;
   localparam int HALF_LSB = 1 << (FRAC_SH - 1);

   // Saturation bounds
   localparam longint H_MAX = (longint'(1) << (HEIGHT_BITS - 1)) - 1;
   localparam longint H_MIN = -(longint'(1) << (HEIGHT_BITS - 1));
   localparam longint V_MAX = (longint'(1) << (VAL_W - 1)) - 1;
   localparam longint V_MIN = -(longint'(1) << (VAL_W - 1));

   // Register reset values
   localparam logic [COEF_W-1:0]       COEF_X_RST = 16'd16057;
   localparam logic [COEF_W-1:0]       COEF_Y_RST = 16'd16057;
   localparam logic [COEF_W-1:0]       DAMP_RST   = 16'd105;
   localparam logic signed [VAL_W-1:0] REST_RST   = 24'sd81920;
   localparam logic signed [VAL_W-1:0] SPLASH_RST = 24'sd110884;
   localparam logic [RAD_W-1:0]        RAD_RST    = 3'd2;

   // Request function codes
   typedef enum logic [FUNC_W-1:0] {
      FN_WRITE  = 3'd0,
      FN_SPLASH = 3'd1,
      FN_STEP   = 3'd2,
      FN_READ   = 3'd3,
      FN_CLEAR  = 3'd4
   } func_type;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_X     = 3'd0,
      CSR_COEF_Y     = 3'd1,
      CSR_DAMPING    = 3'd2,
      CSR_REST       = 3'd3,
      CSR_SPLASH     = 3'd4,
      CSR_SPLASH_RAD = 3'd5
   } csr_idx_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic sweep;
      logic wr_cell;
      logic splash;
      logic step;
      logic respond;
      logic rotate;
   } dwg_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic sweep_last;
      logic splash_last;
      logic step_last;
      logic pipe_busy;
   } dwg_sts_type;

   // Port value to stored cell width, saturating
   function automatic logic signed [HEIGHT_BITS-1:0] sat_to_h(
      input logic signed [VAL_W-1:0] v);
      logic signed [63:0] w;
      w = 64'(v);
      if (w > H_MAX) return HEIGHT_BITS'(H_MAX);
      else if (w < H_MIN) return HEIGHT_BITS'(H_MIN);
      else return HEIGHT_BITS'(w);
   endfunction

   // Stored cell to port value width, saturating
   function automatic logic signed [VAL_W-1:0] sat_to_val(
      input logic signed [HEIGHT_BITS-1:0] v);
      logic signed [63:0] w;
      w = 64'(v);
      if (w > V_MAX) return VAL_W'(V_MAX);
      else if (w < V_MIN) return VAL_W'(V_MIN);
      else return VAL_W'(w);
   endfunction

endpackage

FILE: sv/damped_wave_grid_step.sv
// Top level of the damped 2D wave grid: controller plus datapath.
// Depends on dwg_pkg, dwg_ctrl, dwg_dp (and dwg_ram through dwg_dp).
//
//   channel   direction  handshake                 payload
//   req       in         start & !busy             req_func, req_cell_x, req_cell_y,
//                                                  req_write_value
//   rsp       out        rsp_valid (one cycle)     rsp_height, rsp_status
//   csr       in         csr_valid & csr_ready     csr_index, csr_wdata
//
// One item at a time. Write cell writes and responds in ST_WRITE; unused codes respond
// from ST_RESP; read cell passes ST_READ (RAM read), then ST_RESP. Splash: the clipped
// (2r+1)^2 square is written cell by cell, row by row. Step: one cell per cycle through
// the layer RAM read port, one row of lookahead and a 4-stage stencil pipeline.
// Clear: all three layers written in parallel.
// After reset a fill sweep runs with busy high; csr writes are always taken.
// The result is registered; the receiver cannot stall it.
module damped_wave_grid_step (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [dwg_pkg::FUNC_W-1:0]        req_func,
   input  logic [dwg_pkg::XY_IN_W-1:0]       req_cell_x,
   input  logic [dwg_pkg::XY_IN_W-1:0]       req_cell_y,
   input  logic signed [dwg_pkg::VAL_W-1:0]  req_write_value,
   output logic                              rsp_valid,
   output logic signed [dwg_pkg::VAL_W-1:0]  rsp_height,
   output logic                              rsp_status,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dwg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dwg_pkg::VAL_W-1:0]         csr_wdata
);

   dwg_pkg::dwg_cmd_type cmd;
   dwg_pkg::dwg_sts_type sts;

   assign csr_ready = 1'b1;

   dwg_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .busy     (busy),
      .cmd      (cmd),
      .sts      (sts)
   );

   dwg_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_func        (req_func),
      .req_cell_x      (req_cell_x),
      .req_cell_y      (req_cell_y),
      .req_write_value (req_write_value),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_height      (rsp_height),
      .rsp_status      (rsp_status)
   );

endmodule

FILE: sv/dwg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dwg_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: sv/dwg_ctrl.sv
// Sequencer for the damped wave grid: dispatches requests, runs sweeps and steps.
// Depends on dwg_pkg.
module dwg_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [dwg_pkg::FUNC_W-1:0]     req_func,
   output logic                           busy,
   output dwg_pkg::dwg_cmd_type           cmd,
   input  dwg_pkg::dwg_sts_type           sts
);

   typedef enum logic [8:0] {
      ST_INIT   = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_WRITE  = 9'b000000100,
      ST_SPLASH = 9'b000001000,
      ST_STEP   = 9'b000010000,
      ST_DRAIN  = 9'b000100000,
      ST_READ   = 9'b001000000,
      ST_RESP   = 9'b010000000,
      ST_CLEAR  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               unique case (req_func)
                  dwg_pkg::FN_WRITE:  state_in = ST_WRITE;
                  dwg_pkg::FN_SPLASH: state_in = ST_SPLASH;
                  dwg_pkg::FN_STEP:   state_in = ST_STEP;
                  dwg_pkg::FN_READ:   state_in = ST_READ;
                  dwg_pkg::FN_CLEAR:  state_in = ST_CLEAR;
                  default:            state_in = ST_RESP;
               endcase
            end
         end
         ST_WRITE: begin
            cmd.wr_cell = 1'b1;
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_SPLASH: begin
            cmd.splash = 1'b1;
            if (sts.splash_last) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            if (sts.step_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               cmd.respond = 1'b1;
               cmd.rotate  = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

`ifndef NO_ASSERTIONS
   // an accepted item always leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // back to idle only after a response or the power-up sweep
   a_idle_entry: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> ($past(cmd.respond) || $past(state_ff == ST_INIT)))
      else $error("returned to idle without a response");
`endif

endmodule

FILE: sv/dwg_dp.sv
// Datapath for the damped wave grid: three layer RAMs, stencil pipeline,
// splash and sweep counters, configuration and response registers. Uses dwg_pkg, dwg_ram.
module dwg_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dwg_pkg::dwg_cmd_type                 cmd,
   output dwg_pkg::dwg_sts_type                 sts,
   input  logic [dwg_pkg::FUNC_W-1:0]           req_func,
   input  logic [dwg_pkg::XY_IN_W-1:0]          req_cell_x,
   input  logic [dwg_pkg::XY_IN_W-1:0]          req_cell_y,
   input  logic signed [dwg_pkg::VAL_W-1:0]     req_write_value,
   input  logic                                 csr_valid,
   input  logic [dwg_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dwg_pkg::VAL_W-1:0]            csr_wdata,
   output logic                                 rsp_valid,
   output logic signed [dwg_pkg::VAL_W-1:0]     rsp_height,
   output logic                                 rsp_status
);

   localparam int HB     = dwg_pkg::HEIGHT_BITS;
   localparam int AW     = dwg_pkg::ADDR_W;
   localparam int CW     = dwg_pkg::CRD_W;
   localparam int NW     = dwg_pkg::CNT_W;
   localparam int LW     = dwg_pkg::LAYER_W;
   localparam int SL_LEN = 2 * dwg_pkg::GRID_X;
   // stencil taps in the row window (bottom neighbor comes straight from the RAM)
   localparam int T_CTR  = dwg_pkg::GRID_X - 1;
   localparam int T_RGT  = dwg_pkg::GRID_X - 2;
   localparam int T_LFT  = dwg_pkg::GRID_X;
   localparam int T_TOP  = SL_LEN - 1;

   // ---------------- configuration registers ----------------
   logic [dwg_pkg::COEF_W-1:0]        coef_x_ff, coef_x_in;
   logic [dwg_pkg::COEF_W-1:0]        coef_y_ff, coef_y_in;
   logic [dwg_pkg::COEF_W-1:0]        damp_ff, damp_in;
   logic signed [dwg_pkg::VAL_W-1:0]  rest_ff, rest_in;
   logic signed [dwg_pkg::VAL_W-1:0]  splv_ff, splv_in;
   logic [dwg_pkg::RAD_W-1:0]         rad_ff, rad_in;

   always_comb begin
      coef_x_in = coef_x_ff;
      coef_y_in = coef_y_ff;
      damp_in   = damp_ff;
      rest_in   = rest_ff;
      splv_in   = splv_ff;
      rad_in    = rad_ff;
      if (csr_valid) begin
         unique case (csr_index)
            dwg_pkg::CSR_COEF_X:     coef_x_in = csr_wdata[dwg_pkg::COEF_W-1:0];
            dwg_pkg::CSR_COEF_Y:     coef_y_in = csr_wdata[dwg_pkg::COEF_W-1:0];
            dwg_pkg::CSR_DAMPING:    damp_in   = csr_wdata[dwg_pkg::COEF_W-1:0];
            dwg_pkg::CSR_REST:       rest_in   = $signed(csr_wdata);
            dwg_pkg::CSR_SPLASH:     splv_in   = $signed(csr_wdata);
            dwg_pkg::CSR_SPLASH_RAD: rad_in    = csr_wdata[dwg_pkg::RAD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_x_ff <= dwg_pkg::COEF_X_RST;
         coef_y_ff <= dwg_pkg::COEF_Y_RST;
         damp_ff   <= dwg_pkg::DAMP_RST;
         rest_ff   <= dwg_pkg::REST_RST;
         splv_ff   <= dwg_pkg::SPLASH_RST;
         rad_ff    <= dwg_pkg::RAD_RST;
      end else begin
         coef_x_ff <= coef_x_in;
         coef_y_ff <= coef_y_in;
         damp_ff   <= damp_in;
         rest_ff   <= rest_in;
         splv_ff   <= splv_in;
         rad_ff    <= rad_in;
      end
   end

   logic signed [HB-1:0] rest_h;
   assign rest_h = dwg_pkg::sat_to_h(rest_ff);

   // ---------------- layer roles ----------------
   logic [LW-1:0] newest_ff, newest_in;
   logic [LW-1:0] nxt_lyr, prv_lyr;

   assign nxt_lyr   = (newest_ff == LW'(dwg_pkg::NUM_LAYERS - 1)) ? '0 : newest_ff + 1'b1;
   assign prv_lyr   = (newest_ff == '0) ? LW'(dwg_pkg::NUM_LAYERS - 1) : newest_ff - 1'b1;
   assign newest_in = cmd.rotate ? nxt_lyr : newest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         newest_ff <= '0;
      end else begin
         newest_ff <= newest_in;
      end
   end

   // ---------------- captured request ----------------
   logic [dwg_pkg::FUNC_W-1:0] func_ff;
   logic [AW-1:0]              cell_addr_ff;
   logic                       in_grid_ff;
   logic signed [HB-1:0]       wval_ff;
   logic signed [HB-1:0]       clr_val_ff;
   logic signed [HB-1:0]       spl_val_ff;
   logic [CW-1:0]              cx_in, cy_in, r_in;
   logic [CW-1:0]              x0_in, x1_in, y0_in, y1_in;
   logic [CW-1:0]              x0_ff, x1_ff, y1_ff;

   // clipped splash window
   always_comb begin
      cx_in = CW'(req_cell_x);
      cy_in = CW'(req_cell_y);
      r_in  = CW'(rad_ff);
      x0_in = (cx_in >= r_in) ? cx_in - r_in : '0;
      y0_in = (cy_in >= r_in) ? cy_in - r_in : '0;
      x1_in = (cx_in + r_in > CW'(dwg_pkg::GRID_X - 1)) ? CW'(dwg_pkg::GRID_X - 1)
                                                         : cx_in + r_in;
      y1_in = (cy_in + r_in > CW'(dwg_pkg::GRID_Y - 1)) ? CW'(dwg_pkg::GRID_Y - 1)
                                                         : cy_in + r_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_val_ff <= dwg_pkg::sat_to_h(dwg_pkg::REST_RST);
      end else if (cmd.load) begin
         clr_val_ff <= rest_h;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff      <= req_func;
         cell_addr_ff <= AW'(req_cell_y) * AW'(dwg_pkg::GRID_X) + AW'(req_cell_x);
         in_grid_ff   <= (cx_in < CW'(dwg_pkg::GRID_X)) && (cy_in < CW'(dwg_pkg::GRID_Y));
         wval_ff      <= dwg_pkg::sat_to_h(req_write_value);
         spl_val_ff   <= dwg_pkg::sat_to_h(splv_ff);
         x0_ff        <= x0_in;
         x1_ff        <= x1_in;
         y1_ff        <= y1_in;
      end
   end

   // ---------------- splash scan ----------------
   logic [CW-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic          spl_we;
   logic          spl_row_end;

   assign spl_we      = cmd.splash && (sx_ff <= x1_ff) && (sy_ff <= y1_ff);
   assign spl_row_end = (sx_ff >= x1_ff);

   always_comb begin
      sx_in = sx_ff;
      sy_in = sy_ff;
      if (cmd.load) begin
         sx_in = x0_in;
         sy_in = y0_in;
      end else if (cmd.splash) begin
         if (spl_row_end) begin
            sx_in = x0_ff;
            sy_in = sy_ff + 1'b1;
         end else begin
            sx_in = sx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      sx_ff <= sx_in;
      sy_ff <= sy_in;
   end

   // ---------------- raster counter (sweeps and steps) ----------------
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] stp_x_ff, stp_x_in, stp_y_ff, stp_y_in;
   logic          v0;
   logic [AW-1:0] ctr_addr;

   assign v0       = cmd.step && (cnt_ff >= NW'(dwg_pkg::GRID_X));
   assign ctr_addr = AW'(cnt_ff - NW'(dwg_pkg::GRID_X));

   always_comb begin
      cnt_in   = cnt_ff;
      stp_x_in = stp_x_ff;
      stp_y_in = stp_y_ff;
      if (cmd.load) begin
         cnt_in   = '0;
         stp_x_in = '0;
         stp_y_in = '0;
      end else begin
         if (cmd.sweep || cmd.step) cnt_in = cnt_ff + 1'b1;
         if (v0) begin
            if (stp_x_ff == CW'(dwg_pkg::GRID_X - 1)) begin
               stp_x_in = '0;
               stp_y_in = stp_y_ff + 1'b1;
            end else begin
               stp_x_in = stp_x_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         stp_x_ff <= '0;
         stp_y_ff <= '0;
      end else begin
         cnt_ff   <= cnt_in;
         stp_x_ff <= stp_x_in;
         stp_y_ff <= stp_y_in;
      end
   end

   // ---------------- layer RAMs ----------------
   logic                 ram_we [dwg_pkg::NUM_LAYERS];
   logic [AW-1:0]        ram_wa [dwg_pkg::NUM_LAYERS];
   logic [HB-1:0]        ram_wd [dwg_pkg::NUM_LAYERS];
   logic [AW-1:0]        ram_ra [dwg_pkg::NUM_LAYERS];
   logic [HB-1:0]        ram_rd [dwg_pkg::NUM_LAYERS];
   logic                 cur_we;
   logic [AW-1:0]        cur_wa;
   logic signed [HB-1:0] cur_wd;
   logic [AW-1:0]        cur_ra;
   logic                 nxt_we;
   logic [AW-1:0]        nxt_wa;
   logic signed [HB-1:0] nxt_wd;
   logic signed [HB-1:0] cur_rd, prv_rd;

   // writes into the newest layer: single cell or splash
   assign cur_we = (cmd.wr_cell && in_grid_ff) || spl_we;
   assign cur_wa = cmd.wr_cell ? cell_addr_ff
                               : AW'(sy_ff) * AW'(dwg_pkg::GRID_X) + AW'(sx_ff);
   assign cur_wd = cmd.wr_cell ? wval_ff : spl_val_ff;
   assign cur_ra = cmd.step ? cnt_ff[AW-1:0] : cell_addr_ff;

   for (genvar k = 0; k < dwg_pkg::NUM_LAYERS; k++) begin : g_layer
      always_comb begin
         if (cmd.sweep) begin
            ram_we[k] = 1'b1;
            ram_wa[k] = cnt_ff[AW-1:0];
            ram_wd[k] = clr_val_ff;
         end else if (nxt_lyr == LW'(k)) begin
            ram_we[k] = nxt_we;
            ram_wa[k] = nxt_wa;
            ram_wd[k] = nxt_wd;
         end else begin
            ram_we[k] = cur_we && (newest_ff == LW'(k));
            ram_wa[k] = cur_wa;
            ram_wd[k] = cur_wd;
         end
         ram_ra[k] = (newest_ff == LW'(k)) ? cur_ra : ctr_addr;
      end

      dwg_ram #(
         .WIDTH (HB),
         .DEPTH (dwg_pkg::CELLS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (ram_we[k]),
         .wr_addr (ram_wa[k]),
         .wr_data (ram_wd[k]),
         .rd_addr (ram_ra[k]),
         .rd_data (ram_rd[k])
      );
   end

   assign cur_rd = $signed(ram_rd[newest_ff]);
   assign prv_rd = $signed(ram_rd[prv_lyr]);

   // ---------------- row window of the newest layer ----------------
   logic                 sh_ff;
   logic signed [HB-1:0] sl_ff [SL_LEN];
   logic signed [HB-1:0] sl_in [SL_LEN];

   always_comb begin
      sl_in[0] = sh_ff ? cur_rd : sl_ff[0];
      for (int i = 1; i < SL_LEN; i++) begin
         sl_in[i] = sh_ff ? sl_ff[i-1] : sl_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      sl_ff <= sl_in;
   end

   // ---------------- stencil pipeline ----------------
   logic                        v1_ff, v2_ff, v3_ff, v4_ff;
   logic [AW-1:0]               a1_ff, a2_ff, a3_ff, a4_ff;
   logic [CW-1:0]               s1_x_ff, s1_y_ff;
   logic signed [HB-1:0]        c_v, l_v, r_v, u_v, d_v;
   logic signed [dwg_pkg::LAP_W-1:0] lapx_in, lapy_in, base_in;
   logic signed [dwg_pkg::DIF_W-1:0] diff_in;
   logic signed [dwg_pkg::LAP_W-1:0] lapx_ff, lapy_ff, base_ff, base2_ff;
   logic signed [dwg_pkg::DIF_W-1:0] diff_ff;
   logic signed [dwg_pkg::PRD_W-1:0] px_in, py_in, pd_in, px_ff, py_ff, pd_ff;
   logic signed [dwg_pkg::ACC_W-1:0] acc_in, acc_ff;
   logic signed [dwg_pkg::RND_W-1:0] rnd;
   logic                        sat_hit;
   logic                        sat_ff;

   // neighbors with the rest level outside the grid
   always_comb begin
      c_v = sl_ff[T_CTR];
      l_v = (s1_x_ff == '0) ? rest_h : sl_ff[T_LFT];
      r_v = (s1_x_ff == CW'(dwg_pkg::GRID_X - 1)) ? rest_h : sl_ff[T_RGT];
      u_v = (s1_y_ff == '0) ? rest_h : sl_ff[T_TOP];
      d_v = (s1_y_ff == CW'(dwg_pkg::GRID_Y - 1)) ? rest_h : cur_rd;
      lapx_in = dwg_pkg::LAP_W'(l_v) + dwg_pkg::LAP_W'(r_v) - (dwg_pkg::LAP_W'(c_v) <<< 1);
      lapy_in = dwg_pkg::LAP_W'(u_v) + dwg_pkg::LAP_W'(d_v) - (dwg_pkg::LAP_W'(c_v) <<< 1);
      base_in = (dwg_pkg::LAP_W'(c_v) <<< 1) - dwg_pkg::LAP_W'(prv_rd);
      diff_in = dwg_pkg::DIF_W'(c_v) - dwg_pkg::DIF_W'(prv_rd);
   end

   // coefficient products
   assign px_in = $signed({1'b0, coef_x_ff}) * lapx_ff;
   assign py_in = $signed({1'b0, coef_y_ff}) * lapy_ff;
   assign pd_in = $signed({1'b0, damp_ff}) * diff_ff;

   // Q29.16 sum with the rounding half added
   assign acc_in = (dwg_pkg::ACC_W'(base2_ff) <<< dwg_pkg::FRAC_SH)
                 + dwg_pkg::ACC_W'(px_ff) + dwg_pkg::ACC_W'(py_ff)
                 - dwg_pkg::ACC_W'(pd_ff) + dwg_pkg::ACC_W'(dwg_pkg::HALF_LSB);

   // round, saturate, write the next layer
   always_comb begin
      rnd     = dwg_pkg::RND_W'(acc_ff >>> dwg_pkg::FRAC_SH);
      sat_hit = 1'b0;
      if (rnd > dwg_pkg::RND_W'(dwg_pkg::H_MAX)) begin
         nxt_wd  = HB'(dwg_pkg::H_MAX);
         sat_hit = 1'b1;
      end else if (rnd < dwg_pkg::RND_W'(dwg_pkg::H_MIN)) begin
         nxt_wd  = HB'(dwg_pkg::H_MIN);
         sat_hit = 1'b1;
      end else begin
         nxt_wd = HB'(rnd);
      end
   end

   assign nxt_we = v4_ff;
   assign nxt_wa = a4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sh_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         sh_ff <= cmd.step;
         v1_ff <= v0;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      a1_ff    <= ctr_addr;
      s1_x_ff  <= stp_x_ff;
      s1_y_ff  <= stp_y_ff;
      a2_ff    <= a1_ff;
      lapx_ff  <= lapx_in;
      lapy_ff  <= lapy_in;
      base_ff  <= base_in;
      diff_ff  <= diff_in;
      a3_ff    <= a2_ff;
      px_ff    <= px_in;
      py_ff    <= py_in;
      pd_ff    <= pd_in;
      base2_ff <= base_ff;
      a4_ff    <= a3_ff;
      acc_ff   <= acc_in;
   end

   // saturation flag over one step
   always_ff @(posedge clock) begin
      if (reset) begin
         sat_ff <= 1'b0;
      end else if (cmd.load) begin
         sat_ff <= 1'b0;
      end else if (v4_ff && sat_hit) begin
         sat_ff <= 1'b1;
      end
   end

   // ---------------- status ----------------
   assign sts.sweep_last  = (cnt_ff == NW'(dwg_pkg::CELLS - 1));
   assign sts.step_last   = (cnt_ff == NW'(dwg_pkg::CELLS + dwg_pkg::GRID_X - 1));
   assign sts.splash_last = spl_row_end && (sy_ff >= y1_ff);
   assign sts.pipe_busy   = sh_ff || v1_ff || v2_ff || v3_ff || v4_ff;

   // ---------------- response register ----------------
   logic                             rsp_valid_ff;
   logic signed [dwg_pkg::VAL_W-1:0] rsp_height_ff, rsp_height_in;
   logic                             rsp_status_ff, rsp_status_in;

   always_comb begin
      rsp_height_in = '0;
      rsp_status_in = 1'b0;
      if (func_ff == dwg_pkg::FN_READ) begin
         rsp_height_in = in_grid_ff ? dwg_pkg::sat_to_val(cur_rd)
                                    : dwg_pkg::sat_to_val(rest_h);
      end
      if (func_ff == dwg_pkg::FN_STEP) begin
         rsp_status_in = sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_height_ff <= rsp_height_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_height = rsp_height_ff;
   assign rsp_status = rsp_status_ff;

`ifndef NO_ASSERTIONS
   // one strobe per item, never two in a row
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response strobe held for two cycles");

   // stencil write-back never collides with a clearing sweep
   a_no_sweep_wb: assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> !cmd.sweep)
      else $error("step write-back during sweep");

   // layers rotate only once the pipeline has drained
   a_rotate_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.rotate |-> !(sh_ff || v1_ff || v2_ff || v3_ff || v4_ff))
      else $error("layer rotation with stencil pipeline busy");
`endif

endmodule
